// ----- sv/aes256_pkg.sv -----
// Package for the AES-256 encryption pipeline: payload types, the S-box table
// and the round helper functions. No dependencies.
`default_nettype none
package aes256_pkg;

  localparam int NumRounds = 14;
  localparam int KeyRegs   = 4;

  typedef enum logic [1:0] {
    KEY_PART_0 = 2'd0,
    KEY_PART_1 = 2'd1,
    KEY_PART_2 = 2'd2,
    KEY_PART_3 = 2'd3
  } key_reg_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } plain_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte k of the state sits at bits 8k+7..8k; row k%4, column k/4.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] n;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        n[8*(4*c+r) +: 8] = sbox(s[8*(4*((c+r)%4)+r) +: 8]);
      end
    end
    return n;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] n;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      n[32*c +: 8]    = a0 ^ all ^ gf_double(a0 ^ a1);
      n[32*c+8 +: 8]  = a1 ^ all ^ gf_double(a1 ^ a2);
      n[32*c+16 +: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
      n[32*c+24 +: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
    end
    return n;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage
`default_nettype wire

// ----- sv/aes256_keyexp.sv -----
// Key schedule for the AES-256 pipeline: expands the four key registers into
// the fifteen round keys, one eight-word group per cycle. Uses aes256_pkg.
`default_nettype none
module aes256_keyexp
  import aes256_pkg::*;
(
  input  wire logic         clk,
  input  wire logic [255:0] key,
  output logic [127:0]      round_keys [NumRounds+1]
);

  // Seven registered steps; each turns one eight-word group into the next.
  // Group g lies behind no more key steps than there are round stages ahead of
  // the first round that uses it, so it settles before a block entering after
  // a key write gets there, and a block may enter at any edge after the write.
  logic [255:0] grp [8];
  logic [7:0]   rcon [7];

  assign grp[0] = key;
  assign rcon[0] = 8'h01;

  for (genvar g = 0; g < 7; g++) begin : g_step
    logic [31:0] t0;
    logic [255:0] nxt;
    always_comb begin
      t0 = sub_word({grp[g][7*32 +: 8], grp[g][7*32+24 +: 8],
                     grp[g][7*32+16 +: 8], grp[g][7*32+8 +: 8]})
           ^ {24'h0, rcon[g]};
      nxt[31:0] = grp[g][31:0] ^ t0;
      for (int i = 1; i < 8; i++) begin
        if (i == 4) begin
          nxt[32*i +: 32] = grp[g][32*i +: 32] ^ sub_word(nxt[32*(i-1) +: 32]);
        end else begin
          nxt[32*i +: 32] = grp[g][32*i +: 32] ^ nxt[32*(i-1) +: 32];
        end
      end
    end
    logic [255:0] grp_q;
    always_ff @(posedge clk) begin
      grp_q <= nxt;
    end
    assign grp[g+1] = grp_q;
    if (g < 6) begin : g_rcon
      assign rcon[g+1] = gf_double(rcon[g]);
    end
  end

  for (genvar k = 0; k <= NumRounds; k++) begin : g_rk
    assign round_keys[k] = grp[k/2][128*(k%2) +: 128];
  end

endmodule
`default_nettype wire

// ----- sv/aes256_round.sv -----
// One registered AES round stage: SubBytes, ShiftRows, optional MixColumns
// and the round key addition. Uses aes256_pkg.
`default_nettype none
module aes256_round
  import aes256_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         last,
  input  wire logic         in_valid,
  input  wire logic [127:0] in_state,
  input  wire logic [127:0] round_key,
  output logic              out_valid,
  output logic [127:0]      out_state
);

  logic [127:0] shifted;
  logic [127:0] mixed;

  always_comb begin
    shifted = sub_shift(in_state);
    mixed   = last ? shifted : mix_columns(shifted);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_state <= mixed ^ round_key;
  end

endmodule
`default_nettype wire

// ----- sv/aes256_block_encrypt.sv -----
// AES-256 encryption top level: key registers, key schedule, fifteen stage
// round pipeline. Uses aes256_pkg, aes256_keyexp and aes256_round.
`default_nettype none
// A block accepted at one edge passes stage zero and one register stage per
// round, and leaves with done high as the last round stage registers it.
// Throughput: one block per cycle; busy is never raised, since the results
// cannot be held off and each round has a register stage of its own.
// Reset (rst, synchronous) clears the key registers and all valid bits.
// A block may enter at any edge after a key write; no settling gap is needed.
module aes256_block_encrypt
  import aes256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire plain_t      plain,
  output logic             done,
  output cipher_t          cipher,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0]  key_part [KeyRegs];
  logic [127:0] round_keys [NumRounds+1];
  logic [127:0] st [NumRounds+1];
  logic         vld [NumRounds+1];

  assign busy = 1'b0;

  // The index is two bits wide, so every write lands in one of the four
  // key registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KeyRegs; i++) key_part[i] <= '0;
    end else if (cfg_we) begin
      unique case (key_reg_t'(cfg_index))
        KEY_PART_0: key_part[0] <= cfg_data;
        KEY_PART_1: key_part[1] <= cfg_data;
        KEY_PART_2: key_part[2] <= cfg_data;
        KEY_PART_3: key_part[3] <= cfg_data;
        default:    key_part[0] <= key_part[0];
      endcase
    end
  end

  aes256_keyexp u_keyexp (
    .clk        (clk),
    .key        ({key_part[3], key_part[2], key_part[1], key_part[0]}),
    .round_keys (round_keys)
  );

  // Stage zero registers the beat with the initial key addition.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
    end
    st[0] <= {plain.plain_high, plain.plain_low} ^ round_keys[0];
  end

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aes256_round u_round (
      .clk       (clk),
      .rst       (rst),
      .last      (r == NumRounds),
      .in_valid  (vld[r-1]),
      .in_state  (st[r-1]),
      .round_key (round_keys[r]),
      .out_valid (vld[r]),
      .out_state (st[r])
    );
  end

  assign done   = vld[NumRounds];
  assign cipher = {st[NumRounds][127:64], st[NumRounds][63:0]};

`ifndef SYNTH
  a_pipe_first: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> vld[0]) else $error("beat lost at entry");
  a_pipe_mid: assert property (@(posedge clk) disable iff (rst)
    vld[6] |=> vld[7]) else $error("beat lost mid pipeline");
  a_pipe_out: assert property (@(posedge clk) disable iff (rst)
    vld[NumRounds-1] |=> done) else $error("beat lost at output");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_aes256_block_encrypt.sv -----
// Testbench for aes256_block_encrypt: drives plaintext blocks under several keys
// and checks each ciphertext against an AES-256 predictor kept in this file.
// Depends on aes256_pkg and the aes256_block_encrypt RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_aes256_block_encrypt;
  import aes256_pkg::*;

  localparam int WatchdogLimit = 2000;
  // Idle gap after a key write, before the next block is sent.
  localparam int KeySettle   = 7;
  localparam int DrainCycles = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  plain_t      plain = '0;
  logic        done;
  cipher_t     cipher;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes256_block_encrypt u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .plain(plain),
    .done(done), .cipher(cipher), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // The predictor keeps its own copy of the four key registers.
  logic [63:0] key_words [KeyRegs];
  cipher_t     cipher_queue [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          timed_out = 1'b0;

  // Table S-box, independent of the package's case statement.
  logic [7:0] sbox_tab [256];
  initial begin
    logic [7:0] p, q, x;
    // Walk the multiplicative group with generator 3 and its inverse.
    p = 8'h01;
    q = 8'h01;
    do begin
      p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
      q = q ^ {q[6:0], 1'b0};
      q = q ^ {q[5:0], 2'b00};
      q = q ^ {q[3:0], 4'h0};
      if (q[7]) q = q ^ 8'h09;
      x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
      sbox_tab[p] = x ^ 8'h63;
    end while (p != 8'h01);
    sbox_tab[0] = 8'h63;
  end

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Full AES-256 encryption of one block under the current key copy.
  function automatic cipher_t encrypt_block(input plain_t blk);
    logic [7:0] rk [240];
    logic [7:0] st [16];
    logic [7:0] nx [16];
    logic [7:0] t [4];
    logic [7:0] rcon, tmp, a0, a1, a2, a3, all;
    cipher_t    res;
    rcon = 8'h01;
    for (int k = 0; k < 32; k++) rk[k] = key_words[k / 8][8*(k%8) +: 8];
    for (int i = 8; i < 60; i++) begin
      for (int j = 0; j < 4; j++) t[j] = rk[4*(i-1)+j];
      if (i % 8 == 0) begin
        tmp = t[0];
        t[0] = sbox_tab[t[1]] ^ rcon;
        t[1] = sbox_tab[t[2]];
        t[2] = sbox_tab[t[3]];
        t[3] = sbox_tab[tmp];
        rcon = xtime(rcon);
      end else if (i % 8 == 4) begin
        for (int j = 0; j < 4; j++) t[j] = sbox_tab[t[j]];
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-8)+j] ^ t[j];
    end
    for (int k = 0; k < 16; k++) st[k] = blk[8*k +: 8] ^ rk[k];
    for (int r = 1; r <= NumRounds; r++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) nx[4*c+w] = sbox_tab[st[4*((c+w)%4)+w]];
      if (r != NumRounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = nx[4*c]; a1 = nx[4*c+1]; a2 = nx[4*c+2]; a3 = nx[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          nx[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
          nx[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
          nx[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
          nx[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
        end
      end
      for (int k = 0; k < 16; k++) st[k] = nx[k] ^ rk[16*r+k];
    end
    for (int k = 0; k < 16; k++) res[8*k +: 8] = st[k];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // Result checker: every done strobe is one beat, compared with the oldest
  // outstanding expectation.
  always @(posedge clk) begin
    cipher_t want;
    if (!rst && done) begin
      if (cipher_queue.size() == 0) begin
        report_mismatch("unexpected beat, cipher_low", cipher.cipher_low, 64'h0);
      end else begin
        want = cipher_queue.pop_front();
        if (cipher.cipher_low !== want.cipher_low)
          report_mismatch("cipher_low", cipher.cipher_low, want.cipher_low);
        if (cipher.cipher_high !== want.cipher_high)
          report_mismatch("cipher_high", cipher.cipher_high, want.cipher_high);
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves a beat, whether or not
  // work is outstanding or stimulus is pending.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("** aes256_block_encrypt: FAILED **");
      $finish;
    end
  end

  // Sends one block, after a random gap if allow_gap is set; the gap is zero
  // on a fraction of beats so that back-to-back streams occur. Start is left
  // high after the beat, and dropped only when a gap follows or at drain.
  task automatic send_block(input plain_t blk, input bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 17) : 0;
    if (allow_gap && $urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    plain <= blk;
    @(posedge clk);
    while (busy) @(posedge clk);
    cipher_queue.push_back(encrypt_block(blk));
    @(negedge clk);
  endtask

  // Keeps start high across a run of blocks with no gaps at all.
  task automatic send_burst(input int count);
    plain_t blk;
    for (int n = 0; n < count; n++) begin
      blk = {$urandom, $urandom, $urandom, $urandom};
      start <= 1'b1;
      plain <= blk;
      @(posedge clk);
      while (busy) @(posedge clk);
      cipher_queue.push_back(encrypt_block(blk));
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (cipher_queue.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Key writes happen only with the pipeline empty.
  task automatic load_key(input logic [63:0] k0, k1, k2, k3);
    logic [63:0] parts [KeyRegs];
    key_reg_t    idx;
    parts = '{k0, k1, k2, k3};
    wait_drained();
    for (int i = 0; i < KeyRegs; i++) begin
      idx = key_reg_t'(i);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= parts[i];
      key_words[i] = parts[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    repeat (KeySettle) @(negedge clk);
  endtask

  task automatic test_reset_key();
    // The key registers come out of reset as zero.
    send_block('0, 1'b0);
    send_block('1, 1'b0);
  endtask

  task automatic test_standard_vector();
    // Standard AES-256 test key 00 01 .. 1f and plaintext 00 11 .. ff.
    load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
             64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
    send_block({64'hffeeddccbbaa9988, 64'h7766554433221100}, 1'b0);
  endtask

  task automatic test_extreme_fields();
    load_key('1, '1, '1, '1);
    send_block('0, 1'b0);
    send_block('1, 1'b0);
    send_block({64'h0, 64'h1}, 1'b0);
    send_block({64'h8000000000000000, 64'h0}, 1'b0);
    send_block({64'h5555555555555555, 64'haaaaaaaaaaaaaaaa}, 1'b0);
    load_key(64'h1, 64'h0, 64'h0, 64'h8000000000000000);
    send_block('0, 1'b0);
    send_block('1, 1'b1);
    // A single set bit, moved across the block in steps of seventeen.
    for (int b = 0; b < 128; b += 17) send_block(plain_t'(128'h1 << b), 1'b1);
  endtask

  task automatic test_random_traffic(input int rounds, input int per_key);
    plain_t blk;
    for (int r = 0; r < rounds; r++) begin
      load_key({$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
      for (int n = 0; n < per_key; n++) begin
        if ($urandom_range(0, 9) == 0) send_burst($urandom_range(2, 20));
        blk = {$urandom, $urandom, $urandom, $urandom};
        send_block(blk, $urandom_range(0, 4) != 0);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < KeyRegs; i++) key_words[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_key();
    test_standard_vector();
    test_extreme_fields();
    test_random_traffic(16, 48);
    load_key('0, '0, '0, '0);
    send_block({$urandom, $urandom, $urandom, $urandom}, 1'b1);
    wait_drained();
    if (mismatches == 0 && cipher_queue.size() == 0)
      $display("** aes256_block_encrypt: PASSED **");
    else
      $display("** aes256_block_encrypt: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
